// File: design/okvt_pkg.sv
// Shared types and constants for the ordered key/value table.
`default_nettype none

package okvt_pkg;

   localparam int DEPTH   = 64;
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_GET     = 2'd0,
      CMD_PUT     = 2'd1,
      CMD_REMOVE  = 2'd2,
      CMD_READ_AT = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_ZERO_KEY = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   // Request token that walks down the row of cells, collecting its answer.
   typedef struct packed {
      logic                 active;
      cmd_type              cmd;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
      logic [POS_W-1:0]     position;
      logic [COUNT_W-1:0]   count;
      logic                 found;
      logic                 appended;
      logic [KEY_W-1:0]     out_key;
      logic [VALUE_W-1:0]   out_value;
   } tok_type;

endpackage

`default_nettype wire

// File: design/okvt_cell.sv
// One table slot: holds an entry and serves the token passing through it.
`default_nettype none

module okvt_cell
   import okvt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic [IDX_W-1:0]   cell_index,
   input  wire tok_type            prev_tok,
   input  wire logic               up_pull,
   input  wire logic [KEY_W-1:0]   up_key,
   input  wire logic [VALUE_W-1:0] up_value,
   output tok_type                 tok_ff,
   output logic                    pull_down,
   output logic [KEY_W-1:0]        key_ff,
   output logic [VALUE_W-1:0]      value_ff
);

   tok_type              tok_in;
   logic [KEY_W-1:0]     key_in;
   logic [VALUE_W-1:0]   value_in;
   logic                 live;
   logic                 at_end;
   logic                 match;

   always_comb begin
      live   = {1'b0, cell_index} < prev_tok.count;
      at_end = {1'b0, cell_index} == prev_tok.count;
      match  = live && !prev_tok.found && (key_ff == prev_tok.key);
      tok_in   = prev_tok;
      key_in   = key_ff;
      value_in = value_ff;
      if (prev_tok.active) begin
         case (prev_tok.cmd)
            CMD_GET, CMD_REMOVE: begin
               if (match) begin
                  tok_in.found     = 1'b1;
                  tok_in.out_value = value_ff;
               end
            end
            CMD_PUT: begin
               if (match) begin
                  tok_in.found     = 1'b1;
                  tok_in.out_value = value_ff;
                  value_in         = prev_tok.value;
               end else if (at_end && !prev_tok.found && !prev_tok.appended
                            && (prev_tok.key != '0)) begin
                  tok_in.appended = 1'b1;
                  key_in          = prev_tok.key;
                  value_in        = prev_tok.value;
               end
            end
            CMD_READ_AT: begin
               if (live && (cell_index == prev_tok.position)) begin
                  tok_in.found     = 1'b1;
                  tok_in.out_key   = key_ff;
                  tok_in.out_value = value_ff;
               end
            end
            default: begin
            end
         endcase
      end
      // take the upper neighbor's entry while a removal closes the gap
      if (up_pull) begin
         key_in   = up_key;
         value_in = up_value;
      end
   end

   // once the removed key is behind the token, each cell hands its entry down
   assign pull_down = prev_tok.active && (prev_tok.cmd == CMD_REMOVE) && prev_tok.found;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         key_ff   <= key_in;
         value_ff <= value_in;
      end
   end

endmodule

`default_nettype wire

// File: design/ordered_key_value_table.sv
// Top level of the ordered key/value table: request intake, cell row, result register.
`default_nettype none

// Ordered key/value table of DEPTH (64) entries kept in insertion order in a row
// of cells, cell i holding position i. A request is taken into cell 0 and its
// token moves one cell per clock while the row is not held; each cell compares
// its own entry against it, so a get, put, remove or read-at finishes after
// visiting all DEPTH cells. A put of a new key is appended in the first cell past
// the live entries; a remove makes every later cell hand its entry to its lower
// neighbor as the token goes by, closing the gap. One request is in the row at a
// time: the token passes the cell registers one after another, the result
// register is loaded as the token leaves the last cell, and the result then
// appears on the rsp side. The next request is accepted in the same cycle that
// the result appears, once the token has left the row, so the sustained rate is
// set by the walk along the row.
// A result waiting on rsp does not block intake; only a token reaching the end
// of the row while the result register is still full and not being taken holds
// the row. Every result carries the entry count after the operation. Entry storage
// needs no clearing after reset; only the count and the control flags are reset.
module ordered_key_value_table
   import okvt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // key [31:0], value [63:32], position [69:64], zero [71:70]
   input  wire logic [1:0]  req_tuser,  // cmd [1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // out_key [31:0], out_value [63:32], count [70:64], zero [71]
   output logic [2:0]       rsp_tuser   // hit [0], status [2:1]
);

   tok_type              tok [DEPTH+1];
   logic                 pull [DEPTH+1];
   logic [KEY_W-1:0]     cell_key [DEPTH+1];
   logic [VALUE_W-1:0]   cell_value [DEPTH+1];
   logic [DEPTH-1:0]     active_vec;

   logic                 busy_ff, busy_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 accept;
   logic                 advance;
   logic                 finish;
   tok_type              tail;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign tail       = tok[DEPTH];
   // hold the row only while its finished token cannot enter the result register
   assign advance    = !(tail.active && rsp_valid_ff && !rsp_tready);
   assign finish     = tail.active && advance;

   // build the token that enters cell 0
   always_comb begin
      tok[0]           = '0;
      tok[0].active    = accept;
      tok[0].cmd       = cmd_type'(req_tuser);
      tok[0].key       = req_tdata[31:0];
      tok[0].value     = req_tdata[63:32];
      tok[0].position  = req_tdata[69:64];
      tok[0].count     = count_ff;
   end

   // nothing above the last cell
   assign pull[DEPTH]       = 1'b0;
   assign cell_key[DEPTH]   = '0;
   assign cell_value[DEPTH] = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      okvt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (IDX_W'(g)),
         .prev_tok   (tok[g]),
         .up_pull    (pull[g+1]),
         .up_key     (cell_key[g+1]),
         .up_value   (cell_value[g+1]),
         .tok_ff     (tok[g+1]),
         .pull_down  (pull[g]),
         .key_ff     (cell_key[g]),
         .value_ff   (cell_value[g])
      );
      assign active_vec[g] = tok[g+1].active;
   end

   // turn the finished token into a result and the new entry count
   always_comb begin
      rsp_key_in    = tail.key;
      rsp_value_in  = tail.found ? tail.out_value : '0;
      rsp_hit_in    = tail.found;
      rsp_status_in = ST_OK;
      count_in      = tail.count;
      case (tail.cmd)
         CMD_PUT: begin
            if (tail.key == '0) begin
               rsp_status_in = ST_ZERO_KEY;
            end else if (tail.appended) begin
               count_in = tail.count + COUNT_W'(1);
            end else if (!tail.found) begin
               rsp_status_in = ST_FULL;
            end
         end
         CMD_REMOVE: begin
            if (tail.found) begin
               count_in = tail.count - COUNT_W'(1);
            end
         end
         CMD_READ_AT: begin
            rsp_key_in = tail.found ? tail.out_key : '0;
            if (!tail.found) begin
               rsp_status_in = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            count_ff <= count_in;
         end
      end
   end

   // load the result register as the token leaves the row
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_key_ff    <= rsp_key_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_value_ff, rsp_key_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_hit_ff};

   // the count never passes the table depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("entry count beyond depth");

   // at most one token walks the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(active_vec))
      else $error("more than one token in the cell row");

   // an accepted item closes intake and enters the row
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && tok[1].active))
      else $error("accepted item did not enter the row");

   // a full rejection only ever comes from a full table
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> (rsp_count_ff == COUNT_W'(DEPTH)))
      else $error("full status reported with room left");

endmodule

`default_nettype wire

// File: verif/tb_ordered_key_value_table.sv
// Self-checking testbench for the ordered key/value table: directed and random requests.

module tb_ordered_key_value_table;
   timeunit 1ns;
   timeprecision 1ps;

   import okvt_pkg::*;

   // Cycles without any handshake before the run is declared hung. The limit covers a
   // walk along the row plus sender gaps and receiver stalls, so it is generous.
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_ITEMS  = 1880;
   localparam int POOL_SIZE     = 96;
   localparam int DRAIN_CYCLES  = DEPTH + 40;
   localparam int PROBE_ROWS    = 20;

   // One result item as it should appear on the rsp side.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               hit;
      status_type         status;
      logic [6:0]         count;
   } answer_type;

   // One directed request; answer is used only where typed is set.
   typedef struct packed {
      cmd_type            cmd;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
      logic               typed;
      answer_type         answer;
   } probe_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;  // key [31:0], value [63:32], position [69:64], zero [71:70]
   logic [1:0]  req_tuser = '0;  // cmd [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;       // out_key [31:0], out_value [63:32], count [70:64], zero [71]
   logic [2:0]  rsp_tuser;       // hit [0], status [2:1]

   // Shadow copy of the table contents, updated as each request item is accepted.
   logic [KEY_W-1:0]   shadow_keys   [DEPTH];
   logic [VALUE_W-1:0] shadow_values [DEPTH];
   int                 shadow_count = 0;

   answer_type         pending_answers [$];
   logic [KEY_W-1:0]   key_pool [POOL_SIZE];
   probe_type          probe_table [PROBE_ROWS];
   int                 mismatches = 0;
   int                 idle_cycles = 0;
   bit                 steady = 1'b0;   // set to suppress idling on both sides

   ordered_key_value_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one request to the shadow table and return the result it must produce.
   function automatic answer_type apply_request(cmd_type cmd, logic [KEY_W-1:0] key,
                                                logic [VALUE_W-1:0] value,
                                                logic [POS_W-1:0] position);
      answer_type  ans;
      int          slot;
      ans = '{key: key, value: '0, hit: 1'b0, status: ST_OK, count: '0};
      slot = -1;
      // Stored keys are never zero, so a zero key always misses here.
      for (int i = 0; i < shadow_count; i++) begin
         if (slot < 0 && shadow_keys[i] == key) slot = i;
      end
      case (cmd)
         CMD_GET: begin
            if (slot >= 0) begin
               ans.hit   = 1'b1;
               ans.value = shadow_values[slot];
            end
         end
         CMD_PUT: begin
            if (key == '0) begin
               ans.status = ST_ZERO_KEY;
            end else if (slot >= 0) begin
               // Overwrite always succeeds, even with the table full.
               ans.hit             = 1'b1;
               ans.value           = shadow_values[slot];
               shadow_values[slot] = value;
            end else if (shadow_count >= DEPTH) begin
               ans.status = ST_FULL;
            end else begin
               shadow_keys[shadow_count]   = key;
               shadow_values[shadow_count] = value;
               shadow_count++;
            end
         end
         CMD_REMOVE: begin
            if (slot >= 0) begin
               ans.hit   = 1'b1;
               ans.value = shadow_values[slot];
               // Close the gap: every later entry moves down one position.
               for (int i = slot; i < shadow_count - 1; i++) begin
                  shadow_keys[i]   = shadow_keys[i + 1];
                  shadow_values[i] = shadow_values[i + 1];
               end
               shadow_count--;
            end
         end
         default: begin
            if (position < shadow_count) begin
               ans.hit   = 1'b1;
               ans.key   = shadow_keys[position];
               ans.value = shadow_values[position];
            end else begin
               ans.status = ST_RANGE;
               ans.key    = '0;
            end
         end
      endcase
      ans.count = 7'(shadow_count);
      return ans;
   endfunction

   // Pick a key: mostly from the pool or the live entries, sometimes zero or fully random.
   function automatic logic [KEY_W-1:0] pick_key(bit prefer_live);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return '0;
      if (roll < 7) return $urandom;
      if (prefer_live && shadow_count > 0 && roll < 80)
         return shadow_keys[$urandom_range(0, shadow_count - 1)];
      return key_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // Present one request item, hold it until accepted, then predict its result.
   task automatic send_request(input cmd_type cmd, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] position,
                               output answer_type predicted);
      if (!steady && $urandom_range(0, 99) < 18) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 18);
         // Now and then stretch the gap so it lands at any point of the row walk.
         if ($urandom_range(0, 99) < 5) repeat ($urandom_range(1, 80)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, position, value, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_request(cmd, key, value, position);
   endtask

   initial begin : stimulus
      answer_type       predicted;
      cmd_type          cmd;
      logic [KEY_W-1:0] key;
      logic [POS_W-1:0] position;
      bit               filling;
      int               full_hold;
      int               roll;

      // Directed probes. Typed answers start from an empty table after reset.
      probe_table = '{
         '{CMD_GET,     32'hFFFF_FFFF, 32'h0,         6'd0,  1'b1,
           '{32'hFFFF_FFFF, 32'h0,         1'b0, ST_OK,       7'd0}},
         '{CMD_READ_AT, 32'h0000_1234, 32'h0,         6'd0,  1'b1,
           '{32'h0,         32'h0,         1'b0, ST_RANGE,    7'd0}},
         '{CMD_REMOVE,  32'h0000_0005, 32'h0,         6'd0,  1'b1,
           '{32'h0000_0005, 32'h0,         1'b0, ST_OK,       7'd0}},
         '{CMD_PUT,     32'h0,         32'h0000_1234, 6'd0,  1'b1,
           '{32'h0,         32'h0,         1'b0, ST_ZERO_KEY, 7'd0}},
         '{CMD_PUT,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0,  1'b1,
           '{32'hFFFF_FFFF, 32'h0,         1'b0, ST_OK,       7'd1}},
         '{CMD_PUT,     32'h0000_0001, 32'h0,         6'd0,  1'b1,
           '{32'h0000_0001, 32'h0,         1'b0, ST_OK,       7'd2}},
         '{CMD_PUT,     32'h8000_0000, 32'hAAAA_5555, 6'd0,  1'b1,
           '{32'h8000_0000, 32'h0,         1'b0, ST_OK,       7'd3}},
         '{CMD_GET,     32'hFFFF_FFFF, 32'h0,         6'd0,  1'b1,
           '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,       7'd3}},
         '{CMD_PUT,     32'h0000_0001, 32'h1234_5678, 6'd0,  1'b1,
           '{32'h0000_0001, 32'h0,         1'b1, ST_OK,       7'd3}},
         '{CMD_READ_AT, 32'h0,         32'h0,         6'd2,  1'b1,
           '{32'h8000_0000, 32'hAAAA_5555, 1'b1, ST_OK,       7'd3}},
         '{CMD_READ_AT, 32'hFFFF_FFFF, 32'h0,         6'd63, 1'b1,
           '{32'h0,         32'h0,         1'b0, ST_RANGE,    7'd3}},
         '{CMD_REMOVE,  32'hFFFF_FFFF, 32'h0,         6'd0,  1'b1,
           '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,       7'd2}},
         '{CMD_READ_AT, 32'h0,         32'h0,         6'd0,  1'b1,
           '{32'h0000_0001, 32'h1234_5678, 1'b1, ST_OK,       7'd2}},
         '{CMD_GET,     32'h0,         32'h0,         6'd0,  1'b1,
           '{32'h0,         32'h0,         1'b0, ST_OK,       7'd2}},
         '{CMD_REMOVE,  32'h0,         32'h0,         6'd0,  1'b1,
           '{32'h0,         32'h0,         1'b0, ST_OK,       7'd2}},
         '{CMD_PUT,     32'h5A5A_5A5A, 32'h0F0F_0F0F, 6'd0,  1'b0, '0},
         '{CMD_READ_AT, 32'h0,         32'h0,         6'd2,  1'b0, '0},
         '{CMD_REMOVE,  32'h0000_0001, 32'h0,         6'd0,  1'b0, '0},
         '{CMD_READ_AT, 32'h0,         32'h0,         6'd0,  1'b0, '0},
         '{CMD_GET,     32'h8000_0000, 32'h0,         6'd0,  1'b0, '0}
      };

      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
         if (key_pool[i] == '0) key_pool[i] = 32'h1;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PROBE_ROWS; i++) begin
         send_request(probe_table[i].cmd, probe_table[i].key, probe_table[i].value,
                      probe_table[i].position, predicted);
         pending_answers.push_back(probe_table[i].typed ? probe_table[i].answer : predicted);
      end

      // Random part: alternate fill phases (put heavy, run into a full table and
      // linger there) with drain phases (remove heavy, mostly live keys) down to empty.
      filling   = 1'b1;
      full_hold = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 700 && n < 1000);
         roll   = $urandom_range(0, 99);
         if (filling) begin
            if (roll < 65)      cmd = CMD_PUT;
            else if (roll < 80) cmd = CMD_GET;
            else if (roll < 90) cmd = CMD_READ_AT;
            else                cmd = CMD_REMOVE;
         end else begin
            if (roll < 55)      cmd = CMD_REMOVE;
            else if (roll < 75) cmd = CMD_GET;
            else if (roll < 90) cmd = CMD_READ_AT;
            else                cmd = CMD_PUT;
         end
         key = pick_key(cmd == CMD_REMOVE ? !filling : $urandom_range(0, 1) == 1);
         if ($urandom_range(0, 99) < 70)
            position = (shadow_count == 0) ? '0 : POS_W'($urandom_range(0, shadow_count - 1));
         else
            position = POS_W'($urandom_range(0, DEPTH - 1));
         send_request(cmd, key, $urandom, position, predicted);
         pending_answers.push_back(predicted);

         // Advance the phase from the predicted fill level.
         if (filling) begin
            if (shadow_count == DEPTH) full_hold++;
            if (full_hold >= 20) begin
               filling   = 1'b0;
               full_hold = 0;
            end
         end else if (shadow_count == 0) begin
            filling = 1'b1;
         end
      end
      req_tvalid <= 1'b0;
      steady     = 1'b0;

      // Drain outstanding results, then hold on to catch any extra result item.
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_ordered_key_value_table: clean");
      end else begin
         $display("tb_ordered_key_value_table: errors");
      end
      $finish;
   end

   // Check each result item against the oldest expectation and randomize backpressure.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            $display("%0t: result item with nothing expected, key %h value %h", $time,
                     rsp_tdata[31:0], rsp_tdata[63:32]);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[31:0] !== want.key) begin
               mismatches++;
               $display("%0t: out_key expected %h got %h", $time, want.key, rsp_tdata[31:0]);
            end
            if (rsp_tdata[63:32] !== want.value) begin
               mismatches++;
               $display("%0t: out_value expected %h got %h", $time, want.value,
                        rsp_tdata[63:32]);
            end
            if (rsp_tuser[0] !== want.hit) begin
               mismatches++;
               $display("%0t: hit expected %b got %b", $time, want.hit, rsp_tuser[0]);
            end
            if (rsp_tuser[2:1] !== want.status) begin
               mismatches++;
               $display("%0t: status expected %0d got %0d", $time, want.status,
                        rsp_tuser[2:1]);
            end
            if (rsp_tdata[70:64] !== want.count) begin
               mismatches++;
               $display("%0t: count expected %0d got %0d", $time, want.count,
                        rsp_tdata[70:64]);
            end
         end
      end
      rsp_tready <= steady || ($urandom_range(0, 99) >= 18);
   end

   // Watchdog: end the run if no item moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
         $display("tb_ordered_key_value_table: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
